FILE: sv/sti_pkg.sv
// sti_pkg: shared types and constants of the stack instruction unit
// no dependencies; imported by the stack instruction unit modules

package sti_pkg;

   localparam int unsigned STACK_WORDS = 1024;
   localparam int unsigned ADDR_W      = $clog2(STACK_WORDS);
   localparam int unsigned DATA_W      = 32;
   localparam int unsigned SIZE_W      = 13;
   localparam int unsigned REG_W       = 3;

   // stack pointer after reset: reset base plus reset size
   localparam logic [DATA_W-1:0] SP_RESET   = 32'd4096;
   localparam logic [DATA_W-1:0] BASE_RESET = 32'd0;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;
   localparam logic [SIZE_W-1:0] SIZE_MASK  = 13'h1FFC;
   localparam logic [DATA_W:0]   SIZE_CAP   = (DATA_W+1)'(STACK_WORDS * 4);

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_LSP  = 2'd2,
      OP_SSP  = 2'd3
   } opcode_type;

   typedef enum logic {
      CSR_STACK_BASE = 1'b0,
      CSR_STACK_SIZE = 1'b1
   } csr_index_type;

   typedef enum logic {
      STATUS_OK        = 1'b0,
      STATUS_VIOLATION = 1'b1
   } status_type;

   typedef struct packed {
      logic              write_en;
      logic              read_en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } mem_cmd_type;

   typedef struct packed {
      logic              reg_write;
      logic [REG_W-1:0]  write_index;
      logic [DATA_W-1:0] data;
      logic              status;
      logic              from_mem;
   } exec_result_type;

endpackage

FILE: sv/sti_if.sv
// sti_req_if / sti_rsp_if: valid-ready channels of the stack instruction unit
// depends on sti_pkg for field widths

interface sti_req_if
   import sti_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] instruction;
   logic [DATA_W-1:0] reg_value;

   modport source (output valid, output instruction, output reg_value, input ready);
   modport sink (input valid, input instruction, input reg_value, output ready);
endinterface

interface sti_rsp_if
   import sti_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              reg_write;
   logic [REG_W-1:0]  write_index;
   logic [DATA_W-1:0] write_data;
   logic              status;

   modport source (output valid, output reg_write, output write_index, output write_data,
                   output status, input ready);
   modport sink (input valid, input reg_write, input write_index, input write_data,
                 input status, output ready);
endinterface

FILE: sv/sti_stack_mem.sv
// sti_stack_mem: word-addressed stack storage with registered read data
// depends on sti_pkg for the memory command struct

module sti_stack_mem
   import sti_pkg::*;
(
   input  logic              clock,
   input  mem_cmd_type       cmd,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [STACK_WORDS];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.write_en) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      if (cmd.read_en) begin
         rdata_ff <= mem[cmd.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/sti_exec.sv
// sti_exec: decode, bounds check and stack pointer update for one request
// depends on sti_pkg; drives the stack memory command and the result fields

module sti_exec
   import sti_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [DATA_W-1:0] instruction,
   input  logic [DATA_W-1:0] reg_value,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [DATA_W-1:0] csr_write_data,
   output mem_cmd_type       mem_cmd,
   output exec_result_type   result
);

   logic [DATA_W-1:0] base_ff, base_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [DATA_W-1:0] sp_ff, sp_in;

   opcode_type        opcode;
   logic              imm_flag;
   logic [DATA_W-1:0] src;
   logic [DATA_W:0]   size_masked;
   logic [DATA_W:0]   size_eff;
   logic [DATA_W:0]   limit;
   logic [DATA_W-1:0] sp_dec;
   logic [DATA_W-1:0] sp_inc;
   logic              push_ok;
   logic              pop_ok;
   logic [DATA_W-1:0] addr;
   logic [DATA_W-1:0] offset;

   assign opcode   = opcode_type'(instruction[28:27]);
   assign imm_flag = instruction[26];
   assign src      = imm_flag ? {{(DATA_W-26){instruction[25]}}, instruction[25:0]} : reg_value;

   // effective region size: word multiple, saturated to the memory size
   assign size_masked = (DATA_W+1)'(size_ff & SIZE_MASK);
   assign size_eff    = (size_masked > SIZE_CAP) ? SIZE_CAP : size_masked;
   assign limit       = {1'b0, base_ff} + size_eff;

   assign sp_dec = sp_ff - 32'd4;
   assign sp_inc = sp_ff + 32'd4;

   // push word lies at sp - 4, pop word at sp; limit compared without wrap
   assign push_ok = (sp_ff >= 32'd4) && (sp_dec >= base_ff) && ({1'b0, sp_ff} <= limit);
   assign pop_ok  = (sp_ff >= base_ff) && (({1'b0, sp_ff} + 33'd4) <= limit);

   assign addr   = (opcode == OP_PUSH) ? sp_dec : sp_ff;
   assign offset = addr - base_ff;

   always_comb begin
      mem_cmd.write_en = accept && (opcode == OP_PUSH) && push_ok;
      mem_cmd.read_en  = accept && (opcode == OP_POP) && pop_ok;
      mem_cmd.addr     = offset[ADDR_W+1:2];
      mem_cmd.wdata    = src;
   end

   always_comb begin
      result.reg_write   = 1'b0;
      result.write_index = instruction[25:23];
      result.data        = '0;
      result.status      = STATUS_OK;
      result.from_mem    = 1'b0;
      sp_in              = sp_ff;
      case (opcode)
         OP_PUSH: begin
            if (push_ok) begin
               sp_in = sp_dec;
            end else begin
               result.status = STATUS_VIOLATION;
            end
         end
         OP_POP: begin
            if (pop_ok) begin
               result.reg_write = 1'b1;
               result.from_mem  = 1'b1;
               sp_in            = sp_inc;
            end else begin
               result.status = STATUS_VIOLATION;
            end
         end
         OP_LSP: begin
            result.reg_write = 1'b1;
            result.data      = sp_ff;
         end
         OP_SSP: begin
            sp_in = reg_value;
         end
         default: begin
            sp_in = sp_ff;
         end
      endcase
   end

   always_comb begin
      base_in = base_ff;
      size_in = size_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_STACK_BASE: base_in = csr_write_data;
            CSR_STACK_SIZE: size_in = csr_write_data[SIZE_W-1:0];
            default: begin
               base_in = base_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
         size_ff <= SIZE_RESET;
         sp_ff   <= SP_RESET;
      end else begin
         base_ff <= base_in;
         size_ff <= size_in;
         if (accept) begin
            sp_ff <= sp_in;
         end
      end
   end

endmodule

FILE: sv/stack_instruction_unit.sv
// stack_instruction_unit: top level of the stack instruction unit
// depends on sti_pkg, sti_if, sti_exec and sti_stack_mem

// One instruction request is taken per clock cycle and its response appears
// in the output register in the next cycle; a stalled response holds the
// request port only while the output register is full and not being taken.
// The stack pointer and bounds check are evaluated in the cycle the request
// is taken, and the pop word is read from the single-port stack memory at
// that same edge, so the sustained rate is one instruction per cycle while
// responses are taken. After reset the stack memory contents are undefined;
// base is 0, size 4096 bytes and the stack pointer 4096.

module stack_instruction_unit
   import sti_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   sti_req_if.sink           req,
   sti_rsp_if.source         rsp,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [DATA_W-1:0] csr_write_data
);

   logic              accept;
   mem_cmd_type       mem_cmd;
   exec_result_type   exec_result;
   logic [DATA_W-1:0] mem_rdata;

   logic              valid_ff, valid_in;
   exec_result_type   result_ff;

   assign req.ready = !valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   sti_exec u_exec (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .instruction      (req.instruction),
      .reg_value        (req.reg_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mem_cmd          (mem_cmd),
      .result           (exec_result)
   );

   sti_stack_mem u_mem (
      .clock (clock),
      .cmd   (mem_cmd),
      .rdata (mem_rdata)
   );

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= exec_result;
      end
   end

   // read data register only moves on an accepted pop, so it holds with the result
   assign rsp.valid       = valid_ff;
   assign rsp.reg_write   = result_ff.reg_write;
   assign rsp.write_index = result_ff.write_index;
   assign rsp.write_data  = result_ff.from_mem ? mem_rdata : result_ff.data;
   assign rsp.status      = result_ff.status;

endmodule
